### sv/hfe_pkg.sv
// shared constants, types and helper functions for the homography footprint extent unit
// no dependencies; imported by homography_footprint_extent_unit
package hfe_pkg;

  localparam int HW       = 32;               // homography entry width
  localparam int SZW      = 15;               // image size field width
  localparam int DIM_BITS = 14;               // largest image side is 2**DIM_BITS
  localparam int NW       = HW + DIM_BITS + 2; // projected term width, signed
  localparam int QW       = NW + 1;           // floor / ceil quotient width, signed
  localparam int EW       = QW + 2;           // extent difference width, signed
  localparam int NCORNER  = 4;
  localparam int NLANE    = 2 * NCORNER;      // x and y quotient per corner

  typedef struct packed {
    logic [NW-1:0] rem;
    logic [NW-1:0] quo;
  } div_state_t;

  // clamp a size to 1 .. 2**DIM_BITS and return size minus one
  function automatic logic [DIM_BITS-1:0] last_index(input logic [SZW-1:0] v);
    logic [SZW+1:0] vx;
    logic [SZW+1:0] lim;
    logic [SZW+1:0] d;
    begin
      vx  = {2'b00, v};
      lim = (SZW+2)'(1) << DIM_BITS;
      if (vx == '0) begin
        d = '0;
      end else if (vx > lim) begin
        d = lim - (SZW+2)'(1);
      end else begin
        d = vx - (SZW+2)'(1);
      end
      return d[DIM_BITS-1:0];
    end
  endfunction

  // one restoring division step: one quotient bit per call
  function automatic div_state_t div_step(input div_state_t s, input logic [NW-1:0] den);
    logic [NW:0] trial;
    div_state_t  o;
    begin
      trial = {s.rem, s.quo[NW-1]} - {1'b0, den};
      if (!trial[NW]) begin
        o.rem = trial[NW-1:0];
        o.quo = {s.quo[NW-2:0], 1'b1};
      end else begin
        o.rem = {s.rem[NW-2:0], s.quo[NW-1]};
        o.quo = {s.quo[NW-2:0], 1'b0};
      end
      return o;
    end
  endfunction

endpackage

### sv/homography_footprint_extent_unit.sv
// top level of the homography footprint extent unit: projection, pipelined division, bounding box
// depends on hfe_pkg
//
// One transaction per clock: busy is always low, so a transaction is taken at every edge where
// start is high. Each transaction gives exactly one result, shown for one cycle with done high;
// the receiver cannot hold results off, so results must be taken as they appear. The restoring
// divider gives one quotient bit per stage over NW stages, running the eight x and y quotients
// of the four corners side by side. The corners (0,0), (w-1,0), (w-1,h-1) and (0,h-1) are mapped
// through the homography, divided exactly by the homogeneous term, and the floored minimum and
// ceil(max) - floor(min) + 1 are reported, saturated. A corner with zero homogeneous term sets
// degenerate and zeroes the other result fields.
module homography_footprint_extent_unit
  import hfe_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [HW-1:0]    h00,
  input  logic signed [HW-1:0]    h01,
  input  logic signed [HW-1:0]    h02,
  input  logic signed [HW-1:0]    h10,
  input  logic signed [HW-1:0]    h11,
  input  logic signed [HW-1:0]    h12,
  input  logic signed [HW-1:0]    h20,
  input  logic signed [HW-1:0]    h21,
  input  logic signed [HW-1:0]    h22,
  input  logic [SZW-1:0]          image_width,
  input  logic [SZW-1:0]          image_height,
  output logic                    done,
  output logic signed [31:0]      corner_x,
  output logic signed [31:0]      corner_y,
  output logic [30:0]             extent_width,
  output logic [30:0]             extent_height,
  output logic                    degenerate
);

  localparam int LAT = NW + 8;

  // never stalls
  assign busy = 1'b0;

  // stage 0: capture the transaction and clamp the image size
  logic                   v0;
  logic signed [HW-1:0]   hr [0:8];
  logic [DIM_BITS-1:0]    wm1;
  logic [DIM_BITS-1:0]    hm1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= start;
    end
    hr[0] <= h00; hr[1] <= h01; hr[2] <= h02;
    hr[3] <= h10; hr[4] <= h11; hr[5] <= h12;
    hr[6] <= h20; hr[7] <= h21; hr[8] <= h22;
    wm1   <= last_index(image_width);
    hm1   <= last_index(image_height);
  end

  // stage 1: six products, column entries times w-1 and h-1
  logic                  v1;
  logic signed [NW-1:0]  pu [0:2];   // row r, col 0 times w-1
  logic signed [NW-1:0]  pv [0:2];   // row r, col 1 times h-1
  logic signed [NW-1:0]  pc [0:2];   // row r, col 2
  logic signed [DIM_BITS:0] su;
  logic signed [DIM_BITS:0] sv;

  assign su = $signed({1'b0, wm1});
  assign sv = $signed({1'b0, hm1});

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= v0;
    end
    for (int r = 0; r < 3; r++) begin
      pu[r] <= NW'(hr[3*r] * su);
      pv[r] <= NW'(hr[3*r+1] * sv);
      pc[r] <= NW'(hr[3*r+2]);
    end
  end

  // stage 2: homogeneous terms per corner, row 0 = X, row 1 = Y, row 2 = W
  logic                  v2;
  logic signed [NW-1:0]  term [0:NCORNER-1][0:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    for (int r = 0; r < 3; r++) begin
      term[0][r] <= pc[r];
      term[1][r] <= pu[r] + pc[r];
      term[2][r] <= pu[r] + pv[r] + pc[r];
      term[3][r] <= pv[r] + pc[r];
    end
  end

  // stage 3: move the sign of W into the numerators, split into sign and magnitude
  logic             dv     [0:NW];
  logic             ddeg   [0:NW];
  logic [NLANE-1:0] dneg   [0:NW];
  logic [NW-1:0]    den    [0:NW][0:NCORNER-1];
  div_state_t       dst    [0:NW][0:NLANE-1];

  always_ff @(posedge clk) begin
    logic signed [NW-1:0] wv;
    logic signed [NW-1:0] nx;
    logic signed [NW-1:0] ny;
    logic                 deg;
    if (rst) begin
      dv[0] <= 1'b0;
    end else begin
      dv[0] <= v2;
    end
    deg = 1'b0;
    for (int k = 0; k < NCORNER; k++) begin
      wv = term[k][2];
      nx = term[k][0];
      ny = term[k][1];
      if (wv == '0) begin
        deg = 1'b1;
      end
      if (wv[NW-1]) begin
        wv = -wv;
        nx = -nx;
        ny = -ny;
      end
      den[0][k]           <= wv;
      dneg[0][2*k]        <= nx[NW-1];
      dneg[0][2*k+1]      <= ny[NW-1];
      dst[0][2*k].rem     <= '0;
      dst[0][2*k].quo     <= nx[NW-1] ? -nx : nx;
      dst[0][2*k+1].rem   <= '0;
      dst[0][2*k+1].quo   <= ny[NW-1] ? -ny : ny;
    end
    ddeg[0] <= deg;
  end

  // divider stages: one quotient bit per stage for all eight lanes
  for (genvar s = 0; s < NW; s++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) begin
        dv[s+1] <= 1'b0;
      end else begin
        dv[s+1] <= dv[s];
      end
      ddeg[s+1] <= ddeg[s];
      dneg[s+1] <= dneg[s];
      for (int k = 0; k < NCORNER; k++) begin
        den[s+1][k] <= den[s][k];
      end
      for (int l = 0; l < NLANE; l++) begin
        dst[s+1][l] <= div_step(dst[s][l], den[s][l/2]);
      end
    end
  end

  // floor and ceil from quotient magnitude, remainder and numerator sign
  logic                  v5;
  logic                  deg5;
  logic signed [QW-1:0]  fl [0:NLANE-1];
  logic signed [QW-1:0]  ce [0:NLANE-1];

  always_ff @(posedge clk) begin
    logic signed [QW-1:0] q;
    logic signed [QW-1:0] r;
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= dv[NW];
    end
    deg5 <= ddeg[NW];
    for (int l = 0; l < NLANE; l++) begin
      q = $signed({1'b0, dst[NW][l].quo});
      r = (dst[NW][l].rem != '0) ? QW'(1) : QW'(0);
      if (dneg[NW][l]) begin
        fl[l] <= -q - r;
        ce[l] <= -q;
      end else begin
        fl[l] <= q;
        ce[l] <= q + r;
      end
    end
  end

  // min / max tree, first level: corner pairs (0,1) and (2,3); index 0 = x, 1 = y
  logic                  v6;
  logic                  deg6;
  logic signed [QW-1:0]  mn6 [0:1][0:1];
  logic signed [QW-1:0]  mx6 [0:1][0:1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else begin
      v6 <= v5;
    end
    deg6 <= deg5;
    for (int p = 0; p < 2; p++) begin
      for (int a = 0; a < 2; a++) begin
        mn6[p][a] <= (fl[4*p+a] < fl[4*p+2+a]) ? fl[4*p+a] : fl[4*p+2+a];
        mx6[p][a] <= (ce[4*p+a] > ce[4*p+2+a]) ? ce[4*p+a] : ce[4*p+2+a];
      end
    end
  end

  // second level: full bounding box
  logic                  v7;
  logic                  deg7;
  logic signed [QW-1:0]  mn7 [0:1];
  logic signed [QW-1:0]  mx7 [0:1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else begin
      v7 <= v6;
    end
    deg7 <= deg6;
    for (int a = 0; a < 2; a++) begin
      mn7[a] <= (mn6[0][a] < mn6[1][a]) ? mn6[0][a] : mn6[1][a];
      mx7[a] <= (mx6[0][a] > mx6[1][a]) ? mx6[0][a] : mx6[1][a];
    end
  end

  // output stage: extents and saturation
  logic signed [EW-1:0]  ext [0:1];
  logic [31:0]           cor_sat [0:1];
  logic [30:0]           ext_sat [0:1];

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      ext[a] = EW'(mx7[a]) - EW'(mn7[a]) + EW'(1);
      // corner fits int32 when all bits above bit 31 copy bit 31
      if (mn7[a][QW-1:31] == '0 || mn7[a][QW-1:31] == '1) begin
        cor_sat[a] = mn7[a][31:0];
      end else if (mn7[a][QW-1]) begin
        cor_sat[a] = 32'h8000_0000;
      end else begin
        cor_sat[a] = 32'h7fff_ffff;
      end
      if (ext[a][EW-1]) begin
        ext_sat[a] = '0;
      end else if (ext[a][EW-2:31] != '0) begin
        ext_sat[a] = 31'h7fff_ffff;
      end else begin
        ext_sat[a] = ext[a][30:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v7;
    end
    degenerate    <= deg7;
    corner_x      <= deg7 ? '0 : $signed(cor_sat[0]);
    corner_y      <= deg7 ? '0 : $signed(cor_sat[1]);
    extent_width  <= deg7 ? '0 : ext_sat[0];
    extent_height <= deg7 ? '0 : ext_sat[1];
  end

  // every result follows a matching transaction
  a_latency : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !rst, LAT))
    else $error("result without matching transaction");

  // a degenerate result carries no box
  a_degen_zero : assert property (@(posedge clk) disable iff (rst)
    done && degenerate |-> corner_x == 0 && corner_y == 0 &&
                           extent_width == 0 && extent_height == 0)
    else $error("degenerate result with nonzero fields");

  // ceil is never below floor, so a regular box is at least one pixel
  a_extent_pos : assert property (@(posedge clk) disable iff (rst)
    done && !degenerate |-> extent_width != 0 && extent_height != 0)
    else $error("empty extent on regular result");

endmodule
